[design/spi_flash_command_sequencer_assert.svh]
// assertion macros for the spi flash command sequencer
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// property that must hold at every edge out of reset
`define SFCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies consequence in the next cycle
`define SFCS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

[design/sfcs_pkg.sv]
// shared types, codes and word expansion for the spi flash command sequencer
// no dependencies
`default_nettype none

package sfcs_pkg;

  localparam int ADDR_WIDTH = 24;
  localparam logic [31:0] ADDR_MASK32 = 32'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [23:0] ADDR_MASK = ADDR_MASK32[23:0];

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OPC_CMD     = 2'd0;
  localparam logic [1:0] OPC_PAYLOAD = 2'd1;
  localparam logic [1:0] OPC_FINISH  = 2'd2;
  localparam logic [1:0] OPC_REPLY   = 2'd3;

  localparam logic [2:0] CMD_STATUS = 3'd0;
  localparam logic [2:0] CMD_SECTOR = 3'd1;
  localparam logic [2:0] CMD_BLOCK  = 3'd2;
  localparam logic [2:0] CMD_CHIP   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_PROG   = 3'd5;

  localparam logic [1:0] K_SPI   = 2'd0;
  localparam logic [1:0] K_DATA  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_DESEL = 2'd3;

  localparam logic [7:0] FL_WREN   = 8'h06;
  localparam logic [7:0] FL_RDSR   = 8'h05;
  localparam logic [7:0] FL_SE     = 8'h20;
  localparam logic [7:0] FL_BE     = 8'hD8;
  localparam logic [7:0] FL_CE     = 8'hC7;
  localparam logic [7:0] FL_READ   = 8'h03;
  localparam logic [7:0] FL_PP     = 8'h02;
  localparam logic [7:0] FL_DUMMY  = 8'h00;
  localparam logic [7:0] SR_BUSY   = 8'h01;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STATUS,
    PH_POLL,
    PH_READ,
    PH_RWAIT,
    PH_PROG
  } phase_t;

  typedef enum logic [3:0] {
    J_STATUS,
    J_SECTOR,
    J_BLOCK,
    J_CHIP,
    J_READ,
    J_PROG,
    J_DONE,
    J_RDUMMY,
    J_PBYTE,
    J_RFINISH,
    J_PFINISH,
    J_SDATA,
    J_POLL,
    J_RDATA
  } job_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  reply;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mosi_byte;
    logic       frame_end;
    logic       want_reply;
    logic [7:0] host_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    job_t        job;
    logic [23:0] addr;
    logic [7:0]  dbyte;
  } job_entry_t;

  function automatic logic [2:0] job_len(job_t j);
    logic [2:0] n;
    case (j)
      J_STATUS, J_RFINISH, J_SDATA, J_POLL: n = 3'd2;
      J_SECTOR, J_BLOCK:                    n = 3'd7;
      J_CHIP, J_READ:                       n = 3'd4;
      J_PROG:                               n = 3'd5;
      J_PFINISH:                            n = 3'd3;
      default:                              n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic out_t spi_w(logic [7:0] b, logic fe, logic wr);
    out_t w;
    w = '0;
    w.kind = K_SPI;
    w.mosi_byte = b;
    w.frame_end = fe;
    w.want_reply = wr;
    return w;
  endfunction

  function automatic out_t host_w(logic [1:0] k, logic [7:0] hb);
    out_t w;
    w = '0;
    w.kind = k;
    w.host_byte = hb;
    return w;
  endfunction

  function automatic out_t job_word(job_entry_t e, logic [2:0] idx);
    out_t w;
    logic [23:0] a;
    logic [7:0] eb;
    w = '0;
    a = e.addr & ADDR_MASK;
    eb = (e.job == J_SECTOR) ? FL_SE : FL_BE;
    case (e.job)
      J_STATUS, J_POLL: begin
        w = (idx == 3'd0) ? spi_w(FL_RDSR, 1'b0, 1'b0) : spi_w(FL_DUMMY, 1'b1, 1'b1);
      end
      J_SECTOR, J_BLOCK: begin
        case (idx)
          3'd0:    w = spi_w(FL_WREN, 1'b1, 1'b0);
          3'd1:    w = spi_w(eb, 1'b0, 1'b0);
          3'd2:    w = spi_w(a[23:16], 1'b0, 1'b0);
          3'd3:    w = spi_w(a[15:8], 1'b0, 1'b0);
          3'd4:    w = spi_w(a[7:0], 1'b1, 1'b0);
          3'd5:    w = spi_w(FL_RDSR, 1'b0, 1'b0);
          default: w = spi_w(FL_DUMMY, 1'b1, 1'b1);
        endcase
      end
      J_CHIP: begin
        case (idx)
          3'd0:    w = spi_w(FL_WREN, 1'b1, 1'b0);
          3'd1:    w = spi_w(FL_CE, 1'b1, 1'b0);
          3'd2:    w = spi_w(FL_RDSR, 1'b0, 1'b0);
          default: w = spi_w(FL_DUMMY, 1'b1, 1'b1);
        endcase
      end
      J_READ: begin
        case (idx)
          3'd0:    w = spi_w(FL_READ, 1'b0, 1'b0);
          3'd1:    w = spi_w(a[23:16], 1'b0, 1'b0);
          3'd2:    w = spi_w(a[15:8], 1'b0, 1'b0);
          default: w = spi_w(a[7:0], 1'b0, 1'b0);
        endcase
      end
      J_PROG: begin
        case (idx)
          3'd0:    w = spi_w(FL_WREN, 1'b1, 1'b0);
          3'd1:    w = spi_w(FL_PP, 1'b0, 1'b0);
          3'd2:    w = spi_w(a[23:16], 1'b0, 1'b0);
          3'd3:    w = spi_w(a[15:8], 1'b0, 1'b0);
          default: w = spi_w(a[7:0], 1'b0, 1'b0);
        endcase
      end
      J_RDUMMY: w = spi_w(FL_DUMMY, 1'b0, 1'b1);
      J_PBYTE:  w = spi_w(e.dbyte, 1'b0, 1'b0);
      J_RFINISH: begin
        w = (idx == 3'd0) ? host_w(K_DESEL, 8'h00) : host_w(K_DONE, 8'h00);
      end
      J_PFINISH: begin
        case (idx)
          3'd0:    w = host_w(K_DESEL, 8'h00);
          3'd1:    w = spi_w(FL_RDSR, 1'b0, 1'b0);
          default: w = spi_w(FL_DUMMY, 1'b1, 1'b1);
        endcase
      end
      J_SDATA: begin
        w = (idx == 3'd0) ? host_w(K_DATA, e.dbyte) : host_w(K_DONE, 8'h00);
      end
      J_RDATA: w = host_w(K_DATA, e.dbyte);
      default: w = host_w(K_DONE, 8'h00);
    endcase
    w.last = (idx == job_len(e.job) - 3'd1);
    return w;
  endfunction

endpackage

`default_nettype wire

[design/spi_flash_command_sequencer.sv]
// top level of the spi flash command sequencer: front end, job queue, back end
// depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back
//
//   channel   handshake       payload          direction
//   input     push / full     item   (in_t)    host and bus to block
//   result    pop / empty     result (out_t)   block to spi shifter and host
//
// each input word is accepted while the four-entry job queue has room
// the back end emits one result word per cycle unless a waiting result stalls it;
// an input word yields 0 to 7 results, set by the back end expansion
// a waiting result stalls the back end; the job queue lets the front end keep accepting
// rst is synchronous and clears the phase, queue pointers and output valid
`default_nettype none

module spi_flash_command_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire sfcs_pkg::in_t  item,
  input  wire logic           pop,
  output logic                empty,
  output sfcs_pkg::out_t      result
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_empty;
  sfcs_pkg::job_entry_t q_wdata;
  sfcs_pkg::job_entry_t q_rdata;

  sfcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  sfcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (full),
    .empty   (q_empty)
  );

  sfcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

[design/sfcs_front.sv]
// front end: accepts input words, tracks the protocol phase, classifies into jobs
// depends on sfcs_pkg
`default_nettype none

module sfcs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sfcs_pkg::in_t      item,
  input  wire logic               q_full,
  output logic                    q_push,
  output sfcs_pkg::job_entry_t    q_data
);

  sfcs_pkg::phase_t phase, phase_next;
  sfcs_pkg::job_t   job;
  logic             job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sfcs_pkg::PH_IDLE;
    end else if (push && !q_full) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    job = sfcs_pkg::J_DONE;
    job_valid = 1'b0;
    case (item.op)
      sfcs_pkg::OPC_CMD: begin
        if (phase == sfcs_pkg::PH_IDLE) begin
          job_valid = 1'b1;
          case (item.cmd)
            sfcs_pkg::CMD_STATUS: begin
              job = sfcs_pkg::J_STATUS;
              phase_next = sfcs_pkg::PH_STATUS;
            end
            sfcs_pkg::CMD_SECTOR: begin
              job = sfcs_pkg::J_SECTOR;
              phase_next = sfcs_pkg::PH_POLL;
            end
            sfcs_pkg::CMD_BLOCK: begin
              job = sfcs_pkg::J_BLOCK;
              phase_next = sfcs_pkg::PH_POLL;
            end
            sfcs_pkg::CMD_CHIP: begin
              job = sfcs_pkg::J_CHIP;
              phase_next = sfcs_pkg::PH_POLL;
            end
            sfcs_pkg::CMD_READ: begin
              job = sfcs_pkg::J_READ;
              phase_next = sfcs_pkg::PH_READ;
            end
            sfcs_pkg::CMD_PROG: begin
              job = sfcs_pkg::J_PROG;
              phase_next = sfcs_pkg::PH_PROG;
            end
            default: job = sfcs_pkg::J_DONE;
          endcase
        end
      end
      sfcs_pkg::OPC_PAYLOAD: begin
        if (phase == sfcs_pkg::PH_READ) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_RDUMMY;
          phase_next = sfcs_pkg::PH_RWAIT;
        end else if (phase == sfcs_pkg::PH_PROG) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_PBYTE;
        end
      end
      sfcs_pkg::OPC_FINISH: begin
        if (phase == sfcs_pkg::PH_READ) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_RFINISH;
          phase_next = sfcs_pkg::PH_IDLE;
        end else if (phase == sfcs_pkg::PH_PROG) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_PFINISH;
          phase_next = sfcs_pkg::PH_POLL;
        end
      end
      default: begin
        if (phase == sfcs_pkg::PH_STATUS) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_SDATA;
          phase_next = sfcs_pkg::PH_IDLE;
        end else if (phase == sfcs_pkg::PH_POLL) begin
          job_valid = 1'b1;
          if ((item.reply & sfcs_pkg::SR_BUSY) != 8'h00) begin
            job = sfcs_pkg::J_POLL;
          end else begin
            job = sfcs_pkg::J_DONE;
            phase_next = sfcs_pkg::PH_IDLE;
          end
        end else if (phase == sfcs_pkg::PH_RWAIT) begin
          job_valid = 1'b1;
          job = sfcs_pkg::J_RDATA;
          phase_next = sfcs_pkg::PH_READ;
        end
      end
    endcase
  end

  assign q_push = push && !q_full && job_valid;
  assign q_data.job = job;
  assign q_data.addr = item.addr;
  assign q_data.dbyte = (item.op == sfcs_pkg::OPC_REPLY) ? item.reply : item.wdata;

endmodule

`default_nettype wire

[design/sfcs_queue.sv]
// short job queue between front and back end
// depends on sfcs_pkg
`default_nettype none

module sfcs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire sfcs_pkg::job_entry_t wr_data,
  input  wire logic                 rd_en,
  output sfcs_pkg::job_entry_t      rd_data,
  output logic                      full,
  output logic                      empty
);

  sfcs_pkg::job_entry_t entries [sfcs_pkg::QDEPTH];
  logic [sfcs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [sfcs_pkg::QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data = entries[rd_ptr];
  assign full = (count == (sfcs_pkg::QPTR_W + 1)'(sfcs_pkg::QDEPTH));
  assign empty = (count == '0);

endmodule

`default_nettype wire

[design/sfcs_back.sv]
// back end: expands each queued job into registered result words, one per unstalled cycle
// depends on sfcs_pkg and spi_flash_command_sequencer_assert.svh
`default_nettype none
`include "spi_flash_command_sequencer_assert.svh"

module sfcs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire sfcs_pkg::job_entry_t q_data,
  output logic                      q_pop,
  input  wire logic                 pop,
  output logic                      empty,
  output sfcs_pkg::out_t            result
);

  logic [2:0]     idx;
  logic           out_valid;
  sfcs_pkg::out_t out_word;
  sfcs_pkg::out_t word;
  logic           adv;

  assign word = sfcs_pkg::job_word(q_data, idx);
  assign adv = !q_empty && (!out_valid || pop);
  assign q_pop = adv && word.last;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        idx <= word.last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;
  assign result = out_word;

  `SFCS_ASSERT(a_idx_range, q_empty || (idx < sfcs_pkg::job_len(q_data.job)), "word index past job")
  `SFCS_ASSERT(a_idx_idle, !q_empty || (idx == 3'd0), "word index nonzero with no job")
  `SFCS_ASSERT_NEXT(a_adv_fills, adv, out_valid, "output register not loaded")
  `SFCS_ASSERT_NEXT(a_hold, out_valid && !pop, out_valid && $stable(out_word), "stalled word lost")

endmodule

`default_nettype wire
